// ===== hw/rtl/msc_pkg.sv =====
// ----------------------------------------------------------------------------
// Mobius strip coordinate map package
// Shared constants, types and helper functions for the coordinate map block.
// ----------------------------------------------------------------------------
`default_nettype none

package msc_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int SHIFT_W = (CORDIC_STAGES > 1) ? $clog2(CORDIC_STAGES) : 1;

  // CORDIC datapath word: Q2.30 values and 32-bit binary angles with headroom.
  localparam int CW = 34;
  typedef logic signed [CW-1:0] cval_t;

  localparam cval_t CORDIC_GAIN = 34'sh026DD3B6A;
  localparam cval_t ANG_HALF_PI = 34'sh040000000;
  localparam cval_t ANG_PI = 34'sh080000000;

  localparam int SMALL_ANGLE = 104;

  // Divider geometry: signed dividend, magnitude remainder, quotient bits.
  localparam int DIV_NW = 50;
  localparam int DIV_RW = 52;
  localparam int DIV_QW = 17;
  localparam int DIV_LAT = DIV_QW + 3;

  typedef logic signed [DIV_NW-1:0] dnum_t;
  typedef logic [DIV_RW-1:0] drem_t;
  typedef logic [DIV_QW-1:0] dquo_t;
  typedef logic signed [DIV_QW:0] squo_t;

  typedef struct packed {
    logic neg;
    logic ovf;
  } div_tag_t;

  typedef enum logic [0:0] {
    REG_STRIP_RADIUS,
    REG_HEIGHT_OFFSET
  } reg_idx_t;

  typedef struct packed {
    logic signed [15:0] out_x;
    logic signed [15:0] out_y;
    logic signed [15:0] out_z;
    logic signed [15:0] out_u;
    logic signed [15:0] out_v;
    logic saturated;
  } res_t;

  typedef struct packed {
    logic signed [15:0] val;
    logic clip;
  } sat_t;

  function automatic logic [31:0] atan_val(input int i);
    logic [31:0] r;
    case (i)
      0: r = 32'h20000000;
      1: r = 32'h12E4051E;
      2: r = 32'h09FB385B;
      3: r = 32'h051111D4;
      4: r = 32'h028B0D43;
      5: r = 32'h0145D7E1;
      6: r = 32'h00A2F61E;
      7: r = 32'h00517C55;
      8: r = 32'h0028BE53;
      9: r = 32'h00145F2F;
      10: r = 32'h000A2F98;
      11: r = 32'h000517CC;
      12: r = 32'h00028BE6;
      13: r = 32'h000145F3;
      14: r = 32'h0000A2FA;
      15: r = 32'h0000517D;
      16: r = 32'h000028BE;
      17: r = 32'h0000145F;
      18: r = 32'h00000A30;
      19: r = 32'h00000518;
      20: r = 32'h0000028C;
      21: r = 32'h00000146;
      22: r = 32'h000000A3;
      23: r = 32'h00000051;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

  function automatic sat_t sat16(input logic signed [51:0] a);
    sat_t r;
    if (a > 52'sd32767) begin
      r.val = 16'sh7FFF;
      r.clip = 1'b1;
    end else if (a < -52'sd32768) begin
      r.val = 16'sh8000;
      r.clip = 1'b1;
    end else begin
      r.val = a[15:0];
      r.clip = 1'b0;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/msc_ifs.sv =====
// ----------------------------------------------------------------------------
// Mobius strip coordinate map channels
// Request, response and register write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface msc_req_if;
  logic valid;
  logic ready;
  logic opcode;
  logic signed [15:0] angle_u;
  logic signed [15:0] width_v;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic signed [15:0] pos_z;
  modport source(output valid, opcode, angle_u, width_v, pos_x, pos_y, pos_z,
                 input ready);
  modport sink(input valid, opcode, angle_u, width_v, pos_x, pos_y, pos_z,
               output ready);
endinterface

interface msc_rsp_if;
  logic valid;
  logic ready;
  logic signed [15:0] out_x;
  logic signed [15:0] out_y;
  logic signed [15:0] out_z;
  logic signed [15:0] out_u;
  logic signed [15:0] out_v;
  logic saturated;
  modport source(output valid, out_x, out_y, out_z, out_u, out_v, saturated,
                 input ready);
  modport sink(input valid, out_x, out_y, out_z, out_u, out_v, saturated,
               output ready);
endinterface

interface msc_cfg_if;
  logic valid;
  logic ready;
  msc_pkg::reg_idx_t index;
  logic [15:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/mobius_strip_coordinate_map_core.sv =====
// ----------------------------------------------------------------------------
// Mobius strip coordinate map core
// Forward map from strip parameters (u, v) to a point and inverse map back.
// ----------------------------------------------------------------------------
// Requests enter on req: opcode 0 maps angle_u and width_v to a point,
// opcode 1 maps pos_x, pos_y and pos_z back to out_u and out_v. Each request
// gives exactly one response on rsp, in order. Registers strip_radius
// (index 0) and height_offset (index 1) are written on cfg, which is always
// ready; write them only while no request is in flight.
// The datapath is a chain of registered CORDIC cells (vectoring, then two
// rotation rows) followed by two rows of restoring divider cells. A request
// is taken every cycle while the output skid register is empty.
// When rsp stalls, a skid register holds one more result; after that req
// ready drops and the whole pipeline holds. Synchronous reset empties the
// pipeline and the response registers and restores the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module mobius_strip_coordinate_map_core (
  input wire logic clk,
  input wire logic rst,
  msc_req_if.sink req,
  msc_rsp_if.source rsp,
  msc_cfg_if.sink cfg
);

  localparam int N = msc_pkg::CORDIC_STAGES;
  localparam int DL = msc_pkg::DIV_LAT;
  localparam int CW = msc_pkg::CW;
  localparam int S_ANG = N + 2;
  localparam int S_RPRE = N + 3;
  localparam int S_RPOST = 2 * N + 4;
  localparam int S_DIVB = S_RPOST + DL;
  localparam int S_FIN = S_RPOST + 2 * DL + 1;

  typedef struct packed {
    logic op;
    logic signed [15:0] u;
    logic signed [15:0] v;
    logic signed [15:0] px;
    logic signed [15:0] py;
    logic signed [15:0] pz;
    logic signed [15:0] ang;
    msc_pkg::cval_t z1;
    msc_pkg::cval_t z2;
    logic neg1;
    logic neg2;
    msc_pkg::cval_t cu;
    msc_pkg::cval_t su;
    msc_pkg::cval_t ch;
    msc_pkg::cval_t sh;
    logic signed [49:0] pvc;
    logic signed [49:0] pvs;
    logic signed [17:0] r;
    logic signed [15:0] oz;
    logic fz;
    logic signed [51:0] prx;
    logic signed [51:0] pry;
    logic signed [15:0] ox;
    logic signed [15:0] oy;
    logic fxy;
  } side_t;

  typedef struct packed {
    msc_pkg::cval_t z;
    logic neg;
  } fold_t;

  function automatic fold_t fold(input msc_pkg::cval_t theta);
    fold_t f;
    if (theta > msc_pkg::ANG_HALF_PI) begin
      f.z = theta - msc_pkg::ANG_PI;
      f.neg = 1'b1;
    end else if (theta < -msc_pkg::ANG_HALF_PI) begin
      f.z = theta + msc_pkg::ANG_PI;
      f.neg = 1'b1;
    end else begin
      f.z = theta;
      f.neg = 1'b0;
    end
    return f;
  endfunction

  logic [14:0] strip_radius;
  logic signed [15:0] height_offset;

  logic adv;
  logic [S_FIN:0] vld;
  side_t side_q[0:S_FIN-1];
  side_t side_next[0:S_FIN-1];
  msc_pkg::res_t res_q;
  msc_pkg::res_t res_main;
  msc_pkg::res_t res_skid;
  logic main_v;
  logic skid_v;

  msc_pkg::cval_t vp_x, vp_y, vp_acc;
  msc_pkg::cval_t vx[0:N];
  msc_pkg::cval_t vy[0:N];
  msc_pkg::cval_t vacc[0:N];
  msc_pkg::cval_t rx1[0:N];
  msc_pkg::cval_t ry1[0:N];
  msc_pkg::cval_t rz1[0:N];
  msc_pkg::cval_t rx2[0:N];
  msc_pkg::cval_t ry2[0:N];
  msc_pkg::cval_t rz2[0:N];

  msc_pkg::cval_t sx0, sy0;
  logic [31:0] ang_rnd;
  logic signed [15:0] ou;
  fold_t f1, f2;
  logic signed [51:0] r_sum;
  msc_pkg::sat_t z_sat, x_sat, y_sat, v_sat;
  msc_pkg::dnum_t num_a, num_b;
  msc_pkg::cval_t den_b;
  msc_pkg::squo_t quo_a, quo_b;
  logic near_zero;
  side_t sb;
  side_t sf;

  // Register writes.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      strip_radius <= 15'd256;
      height_offset <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        msc_pkg::REG_STRIP_RADIUS: strip_radius <= cfg.data[14:0];
        msc_pkg::REG_HEIGHT_OFFSET: height_offset <= cfg.data;
        default: ;
      endcase
    end
  end

  // Pipeline control with an output skid register.
  assign adv = !skid_v;
  assign req.ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[S_FIN-1:0], req.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      main_v <= 1'b0;
      skid_v <= 1'b0;
    end else if (skid_v) begin
      if (rsp.ready) begin
        res_main <= res_skid;
        skid_v <= 1'b0;
      end
    end else if (!main_v || rsp.ready) begin
      main_v <= vld[S_FIN];
      res_main <= res_q;
    end else if (vld[S_FIN]) begin
      res_skid <= res_q;
      skid_v <= 1'b1;
    end
  end

  assign rsp.valid = main_v;
  assign rsp.out_x = res_main.out_x;
  assign rsp.out_y = res_main.out_y;
  assign rsp.out_z = res_main.out_z;
  assign rsp.out_u = res_main.out_u;
  assign rsp.out_v = res_main.out_v;
  assign rsp.saturated = res_main.saturated;

  // Vectoring row: atan2 of the point.
  assign sx0 = CW'(side_q[0].px) <<< 14;
  assign sy0 = CW'(side_q[0].py) <<< 14;

  always_ff @(posedge clk) begin
    if (adv) begin
      if (sx0 < 0) begin
        vp_x <= -sx0;
        vp_y <= -sy0;
        vp_acc <= msc_pkg::ANG_PI;
      end else begin
        vp_x <= sx0;
        vp_y <= sy0;
        vp_acc <= '0;
      end
    end
  end

  assign vx[0] = vp_x;
  assign vy[0] = vp_y;
  assign vacc[0] = vp_acc;

  for (genvar j = 0; j < N; j++) begin : g_vec
    msc_vec_cell u_vec (
      .clk       (clk),
      .en        (adv),
      .shift     (msc_pkg::SHIFT_W'(j)),
      .angle_step(msc_pkg::atan_val(j)),
      .x_in      (vx[j]),
      .y_in      (vy[j]),
      .acc_in    (vacc[j]),
      .x_out     (vx[j+1]),
      .y_out     (vy[j+1]),
      .acc_out   (vacc[j+1])
    );
  end

  assign ang_rnd = vacc[N][31:0] + 32'h00008000;
  assign ou = (side_q[S_ANG-1].px == 0 && side_q[S_ANG-1].py == 0) ? 16'sd0 :
              $signed(ang_rnd[31:16]);

  // Rotation rows: cos/sin of u and of u/2.
  assign f1 = fold(CW'($signed({side_q[S_RPRE-1].ang, 16'd0})));
  assign f2 = fold(CW'($signed({side_q[S_RPRE-1].ang, 15'd0})));

  assign rx1[0] = msc_pkg::CORDIC_GAIN;
  assign ry1[0] = '0;
  assign rz1[0] = side_q[S_RPRE].z1;
  assign rx2[0] = msc_pkg::CORDIC_GAIN;
  assign ry2[0] = '0;
  assign rz2[0] = side_q[S_RPRE].z2;

  for (genvar j = 0; j < N; j++) begin : g_rot
    msc_rot_cell u_rot_full (
      .clk       (clk),
      .en        (adv),
      .shift     (msc_pkg::SHIFT_W'(j)),
      .angle_step(msc_pkg::atan_val(j)),
      .x_in      (rx1[j]),
      .y_in      (ry1[j]),
      .z_in      (rz1[j]),
      .x_out     (rx1[j+1]),
      .y_out     (ry1[j+1]),
      .z_out     (rz1[j+1])
    );
    msc_rot_cell u_rot_half (
      .clk       (clk),
      .en        (adv),
      .shift     (msc_pkg::SHIFT_W'(j)),
      .angle_step(msc_pkg::atan_val(j)),
      .x_in      (rx2[j]),
      .y_in      (ry2[j]),
      .z_in      (rz2[j]),
      .x_out     (rx2[j+1]),
      .y_out     (ry2[j+1]),
      .z_out     (rz2[j+1])
    );
  end

  // Forward products and saturation.
  assign r_sum = ($signed({37'd0, strip_radius}) <<< 30) + 52'(side_q[S_RPOST+1].pvc) +
                 (52'sd1 <<< 29);
  assign z_sat = msc_pkg::sat16(((52'(side_q[S_RPOST+1].pvs) + (52'sd1 <<< 29)) >>> 30) +
                                52'(height_offset));
  assign x_sat = msc_pkg::sat16((side_q[S_RPOST+3].prx + (52'sd1 <<< 29)) >>> 30);
  assign y_sat = msc_pkg::sat16((side_q[S_RPOST+3].pry + (52'sd1 <<< 29)) >>> 30);

  // Inverse divisions.
  assign num_a = msc_pkg::dnum_t'(side_q[S_RPOST].px) <<< 30;

  msc_div_pipe u_div_a (
    .clk(clk),
    .en (adv),
    .num(num_a),
    .den(side_q[S_RPOST].cu),
    .quo(quo_a)
  );

  assign sb = side_q[S_DIVB];
  assign near_zero = !(sb.ang > $signed(16'(msc_pkg::SMALL_ANGLE)) ||
                       sb.ang < -$signed(16'(msc_pkg::SMALL_ANGLE)));
  assign num_b = near_zero ?
      (msc_pkg::dnum_t'(quo_a) - msc_pkg::dnum_t'($signed({1'b0, strip_radius}))) <<< 30 :
      (msc_pkg::dnum_t'(sb.pz) - msc_pkg::dnum_t'(height_offset)) <<< 30;
  assign den_b = near_zero ? sb.ch : sb.sh;

  msc_div_pipe u_div_b (
    .clk(clk),
    .en (adv),
    .num(num_b),
    .den(den_b),
    .quo(quo_b)
  );

  assign sf = side_q[S_FIN-1];
  assign v_sat = msc_pkg::sat16(52'(quo_b));

  // Side data that travels with each request.
  always_comb begin
    side_next[0] = '0;
    side_next[0].op = req.opcode;
    side_next[0].u = req.angle_u;
    side_next[0].v = req.width_v;
    side_next[0].px = req.pos_x;
    side_next[0].py = req.pos_y;
    side_next[0].pz = req.pos_z;
    for (int k = 1; k < S_FIN; k++) begin
      side_next[k] = side_q[k-1];
    end
    side_next[S_ANG].ang = side_q[S_ANG-1].op ? ou : side_q[S_ANG-1].u;
    side_next[S_RPRE].z1 = f1.z;
    side_next[S_RPRE].neg1 = f1.neg;
    side_next[S_RPRE].z2 = f2.z;
    side_next[S_RPRE].neg2 = f2.neg;
    side_next[S_RPOST].cu = side_q[S_RPOST-1].neg1 ? -rx1[N] : rx1[N];
    side_next[S_RPOST].su = side_q[S_RPOST-1].neg1 ? -ry1[N] : ry1[N];
    side_next[S_RPOST].ch = side_q[S_RPOST-1].neg2 ? -rx2[N] : rx2[N];
    side_next[S_RPOST].sh = side_q[S_RPOST-1].neg2 ? -ry2[N] : ry2[N];
    side_next[S_RPOST+1].pvc = side_q[S_RPOST].v * side_q[S_RPOST].ch;
    side_next[S_RPOST+1].pvs = side_q[S_RPOST].v * side_q[S_RPOST].sh;
    side_next[S_RPOST+2].r = r_sum[47:30];
    side_next[S_RPOST+2].oz = z_sat.val;
    side_next[S_RPOST+2].fz = z_sat.clip;
    side_next[S_RPOST+3].prx = side_q[S_RPOST+2].r * side_q[S_RPOST+2].cu;
    side_next[S_RPOST+3].pry = side_q[S_RPOST+2].r * side_q[S_RPOST+2].su;
    side_next[S_RPOST+4].ox = x_sat.val;
    side_next[S_RPOST+4].oy = y_sat.val;
    side_next[S_RPOST+4].fxy = x_sat.clip | y_sat.clip;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side_q <= side_next;
      if (sf.op) begin
        res_q.out_x <= '0;
        res_q.out_y <= '0;
        res_q.out_z <= '0;
        res_q.out_u <= sf.ang;
        res_q.out_v <= v_sat.val;
        res_q.saturated <= v_sat.clip;
      end else begin
        res_q.out_x <= sf.ox;
        res_q.out_y <= sf.oy;
        res_q.out_z <= sf.oz;
        res_q.out_u <= '0;
        res_q.out_v <= '0;
        res_q.saturated <= sf.fz | sf.fxy;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/msc_vec_cell.sv =====
// ----------------------------------------------------------------------------
// Vectoring CORDIC cell
// One registered micro-rotation that drives y toward zero and sums the angle.
// ----------------------------------------------------------------------------
`default_nettype none

module msc_vec_cell (
  input  wire logic clk,
  input  wire logic en,
  input  wire logic [msc_pkg::SHIFT_W-1:0] shift,
  input  wire logic [31:0] angle_step,
  input  wire msc_pkg::cval_t x_in,
  input  wire msc_pkg::cval_t y_in,
  input  wire msc_pkg::cval_t acc_in,
  output msc_pkg::cval_t x_out,
  output msc_pkg::cval_t y_out,
  output msc_pkg::cval_t acc_out
);

  msc_pkg::cval_t step;

  assign step = msc_pkg::cval_t'({2'b00, angle_step});

  always_ff @(posedge clk) begin
    if (en) begin
      if (y_in > 0) begin
        x_out <= x_in + (y_in >>> shift);
        y_out <= y_in - (x_in >>> shift);
        acc_out <= acc_in + step;
      end else begin
        x_out <= x_in - (y_in >>> shift);
        y_out <= y_in + (x_in >>> shift);
        acc_out <= acc_in - step;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/msc_rot_cell.sv =====
// ----------------------------------------------------------------------------
// Rotation CORDIC cell
// One registered micro-rotation that drives the residual angle toward zero.
// ----------------------------------------------------------------------------
`default_nettype none

module msc_rot_cell (
  input  wire logic clk,
  input  wire logic en,
  input  wire logic [msc_pkg::SHIFT_W-1:0] shift,
  input  wire logic [31:0] angle_step,
  input  wire msc_pkg::cval_t x_in,
  input  wire msc_pkg::cval_t y_in,
  input  wire msc_pkg::cval_t z_in,
  output msc_pkg::cval_t x_out,
  output msc_pkg::cval_t y_out,
  output msc_pkg::cval_t z_out
);

  msc_pkg::cval_t step;

  assign step = msc_pkg::cval_t'({2'b00, angle_step});

  always_ff @(posedge clk) begin
    if (en) begin
      if (z_in >= 0) begin
        x_out <= x_in - (y_in >>> shift);
        y_out <= y_in + (x_in >>> shift);
        z_out <= z_in - step;
      end else begin
        x_out <= x_in + (y_in >>> shift);
        y_out <= y_in - (x_in >>> shift);
        z_out <= z_in + step;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/msc_div_cell.sv =====
// ----------------------------------------------------------------------------
// Restoring divider cell
// Resolves one quotient bit by a trial subtract of the shifted divisor.
// ----------------------------------------------------------------------------
`default_nettype none

module msc_div_cell (
  input  wire logic clk,
  input  wire logic en,
  input  wire logic [$clog2(msc_pkg::DIV_QW)-1:0] bit_pos,
  input  wire msc_pkg::drem_t rem_in,
  input  wire msc_pkg::drem_t dsr_in,
  input  wire msc_pkg::dquo_t quo_in,
  input  wire msc_pkg::div_tag_t tag_in,
  output msc_pkg::drem_t rem_out,
  output msc_pkg::drem_t dsr_out,
  output msc_pkg::dquo_t quo_out,
  output msc_pkg::div_tag_t tag_out
);

  msc_pkg::drem_t trial;

  assign trial = dsr_in << bit_pos;

  always_ff @(posedge clk) begin
    if (en) begin
      dsr_out <= dsr_in;
      tag_out <= tag_in;
      if (rem_in >= trial) begin
        rem_out <= rem_in - trial;
        quo_out <= quo_in | (msc_pkg::dquo_t'(1) << bit_pos);
      end else begin
        rem_out <= rem_in;
        quo_out <= quo_in;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/msc_div_pipe.sv =====
// ----------------------------------------------------------------------------
// Pipelined rounding divider
// Signed division rounded to nearest, ties away from zero, one bit per cell.
// ----------------------------------------------------------------------------
`default_nettype none

module msc_div_pipe (
  input  wire logic clk,
  input  wire logic en,
  input  wire msc_pkg::dnum_t num,
  input  wire msc_pkg::cval_t den,
  output msc_pkg::squo_t quo
);

  localparam int QW = msc_pkg::DIV_QW;
  localparam int RW = msc_pkg::DIV_RW;
  localparam int BW = $clog2(QW);

  logic [msc_pkg::DIV_NW-1:0] p1_un;
  logic [msc_pkg::CW-1:0] p1_ud;
  logic p1_neg;

  msc_pkg::drem_t np;
  msc_pkg::drem_t dp;

  msc_pkg::drem_t rem[0:QW];
  msc_pkg::drem_t dsr[0:QW];
  msc_pkg::dquo_t qv[0:QW];
  msc_pkg::div_tag_t tag[0:QW];

  msc_pkg::drem_t p2_rem;
  msc_pkg::drem_t p2_dsr;
  msc_pkg::div_tag_t p2_tag;

  msc_pkg::dquo_t q_fin;

  assign np = (RW'(p1_un) << 1) + RW'(p1_ud);
  assign dp = RW'(p1_ud) << 1;

  always_ff @(posedge clk) begin
    if (en) begin
      p1_un <= num[msc_pkg::DIV_NW-1] ? msc_pkg::DIV_NW'(-num) : msc_pkg::DIV_NW'(num);
      p1_ud <= den[msc_pkg::CW-1] ? msc_pkg::CW'(-den) : msc_pkg::CW'(den);
      p1_neg <= num[msc_pkg::DIV_NW-1] ^ den[msc_pkg::CW-1];
      p2_rem <= np;
      p2_dsr <= dp;
      p2_tag.neg <= p1_neg;
      p2_tag.ovf <= np >= (dp << QW);
    end
  end

  assign rem[0] = p2_rem;
  assign dsr[0] = p2_dsr;
  assign qv[0] = '0;
  assign tag[0] = p2_tag;

  for (genvar j = 0; j < QW; j++) begin : g_cell
    msc_div_cell u_cell (
      .clk    (clk),
      .en     (en),
      .bit_pos(BW'(QW - 1 - j)),
      .rem_in (rem[j]),
      .dsr_in (dsr[j]),
      .quo_in (qv[j]),
      .tag_in (tag[j]),
      .rem_out(rem[j+1]),
      .dsr_out(dsr[j+1]),
      .quo_out(qv[j+1]),
      .tag_out(tag[j+1])
    );
  end

  assign q_fin = tag[QW].ovf ? '1 : qv[QW];

  always_ff @(posedge clk) begin
    if (en) begin
      quo <= tag[QW].neg ? -$signed({1'b0, q_fin}) : $signed({1'b0, q_fin});
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/msc_checker.sv =====
// ----------------------------------------------------------------------------
// Mobius strip coordinate map checker
// Port-level properties of the coordinate map core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module msc_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic req_valid,
  input wire logic req_ready,
  input wire logic rsp_valid,
  input wire logic rsp_ready,
  input wire logic signed [15:0] out_x,
  input wire logic signed [15:0] out_y,
  input wire logic signed [15:0] out_z,
  input wire logic signed [15:0] out_u,
  input wire logic signed [15:0] out_v,
  input wire logic saturated
);

  // A response carries either a point or strip parameters, never both.
  a_one_kind: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (out_u != 0 || out_v != 0) |-> out_x == 0 && out_y == 0 && out_z == 0)
    else $error("response carries both a point and strip parameters");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("response valid right after reset");

  // Requests are refused only while a response is waiting.
  a_ready_backpressure: assert property (@(posedge clk) disable iff (rst)
    !req_ready |-> rsp_valid)
    else $error("request refused with no response pending");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(out_x) && $stable(out_y) &&
      $stable(out_z) && $stable(out_u) && $stable(out_v) && $stable(saturated))
    else $error("stalled response changed");

endmodule

bind mobius_strip_coordinate_map_core msc_checker u_msc_checker (
  .clk      (clk),
  .rst      (rst),
  .req_valid(req.valid),
  .req_ready(req.ready),
  .rsp_valid(rsp.valid),
  .rsp_ready(rsp.ready),
  .out_x    (rsp.out_x),
  .out_y    (rsp.out_y),
  .out_z    (rsp.out_z),
  .out_u    (rsp.out_u),
  .out_v    (rsp.out_v),
  .saturated(rsp.saturated)
);

`default_nettype wire
